FILE: hdl/pdds_pkg.sv
// Shared types and constants for the drive-straight PD controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdds_pkg;

   localparam int GAIN_W      = 16;
   localparam int SPEED_W     = 7;
   localparam int CORR_W      = 6;
   localparam int CMD_W       = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int RSP_DATA_W  = 24;

   localparam logic [SPEED_W-1:0] LOW_FLOOR  = 7'd20;
   localparam logic [SPEED_W-1:0] HEAD_LIMIT = 7'd127;

   localparam logic [GAIN_W-1:0]  KP_RESET        = 16'd451;
   localparam logic [GAIN_W-1:0]  KD_RESET        = 16'd6144;
   localparam logic [GAIN_W-1:0]  HEAD_KP_RESET   = 16'd0;
   localparam logic [GAIN_W-1:0]  HEAD_KD_RESET   = 16'd0;
   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 7'd127;
   localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 7'd25;
   localparam logic [CORR_W-1:0]  MAX_CORR_RESET  = 6'd30;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TARGET    = 3'd0,
      REG_KP        = 3'd1,
      REG_KD        = 3'd2,
      REG_HEAD_KP   = 3'd3,
      REG_HEAD_KD   = 3'd4,
      REG_MAX_SPEED = 3'd5,
      REG_MIN_SPEED = 3'd6,
      REG_MAX_CORR  = 3'd7
   } reg_idx_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  kp_gain;
      logic [GAIN_W-1:0]  kd_gain;
      logic [GAIN_W-1:0]  heading_kp_gain;
      logic [GAIN_W-1:0]  heading_kd_gain;
      logic [SPEED_W-1:0] max_speed;
      logic [SPEED_W-1:0] min_speed;
      logic [CORR_W-1:0]  max_corrections;
   } cfg_type;

   typedef struct packed {
      logic        gave_up;
      logic        done_res;
      logic [CMD_W-1:0] heading_cmd;
      logic [CMD_W-1:0] drive_cmd;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/pdds_csr.sv
// Configuration register file of the drive-straight PD controller.
// Depends on pdds_pkg.
`default_nettype none

module pdds_csr #(
   parameter int COUNT_WIDTH = 24,
   parameter int CSR_DATA_W  = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [pdds_pkg::CSR_ADDR_W-1:0] wr_addr,
   input  wire logic [CSR_DATA_W-1:0]           wr_data,
   output logic [COUNT_WIDTH-1:0]               target,
   output pdds_pkg::cfg_type                    cfg
);
   import pdds_pkg::*;

   logic [COUNT_WIDTH-1:0] target_ff, target_in;
   cfg_type                cfg_ff, cfg_in;

   always_comb begin
      target_in = target_ff;
      cfg_in    = cfg_ff;
      if (wr_en) begin
         case (reg_idx_type'(wr_addr))
            REG_TARGET:    target_in              = wr_data[COUNT_WIDTH-1:0];
            REG_KP:        cfg_in.kp_gain         = wr_data[GAIN_W-1:0];
            REG_KD:        cfg_in.kd_gain         = wr_data[GAIN_W-1:0];
            REG_HEAD_KP:   cfg_in.heading_kp_gain = wr_data[GAIN_W-1:0];
            REG_HEAD_KD:   cfg_in.heading_kd_gain = wr_data[GAIN_W-1:0];
            REG_MAX_SPEED: cfg_in.max_speed       = wr_data[SPEED_W-1:0];
            REG_MIN_SPEED: cfg_in.min_speed       = wr_data[SPEED_W-1:0];
            REG_MAX_CORR:  cfg_in.max_corrections = wr_data[CORR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff              <= '0;
         cfg_ff.kp_gain         <= KP_RESET;
         cfg_ff.kd_gain         <= KD_RESET;
         cfg_ff.heading_kp_gain <= HEAD_KP_RESET;
         cfg_ff.heading_kd_gain <= HEAD_KD_RESET;
         cfg_ff.max_speed       <= MAX_SPEED_RESET;
         cfg_ff.min_speed       <= MIN_SPEED_RESET;
         cfg_ff.max_corrections <= MAX_CORR_RESET;
      end else begin
         target_ff <= target_in;
         cfg_ff    <= cfg_in;
      end
   end

   assign target = target_ff;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/pdds_pd_term.sv
// PD term q = kp*err + kd*(err - prev), exact, gains unsigned fixed point.
// Depends on pdds_pkg.
`default_nettype none

module pdds_pd_term #(
   parameter int ERR_W = 25,
   parameter int Q_W   = 44
) (
   input  wire logic [pdds_pkg::GAIN_W-1:0] kp,
   input  wire logic [pdds_pkg::GAIN_W-1:0] kd,
   input  wire logic signed [ERR_W-1:0]     err,
   input  wire logic signed [ERR_W-1:0]     prev,
   output logic signed [Q_W-1:0]            q
);
   import pdds_pkg::*;

   logic signed [GAIN_W:0]         kp_s;
   logic signed [GAIN_W:0]         kd_s;
   logic signed [ERR_W:0]          diff;
   logic signed [ERR_W+GAIN_W:0]   p_term;
   logic signed [ERR_W+GAIN_W+1:0] d_term;

   assign kp_s   = $signed({1'b0, kp});
   assign kd_s   = $signed({1'b0, kd});
   assign diff   = $signed({err[ERR_W-1], err}) - $signed({prev[ERR_W-1], prev});
   assign p_term = kp_s * err;
   assign d_term = kd_s * diff;
   assign q      = Q_W'(p_term) + Q_W'(d_term);

endmodule

`default_nettype wire

FILE: hdl/pdds_ctrl.sv
// Move state and command shaping: PD terms, clamp, speed floor, heading
// saturation and error update. Depends on pdds_pkg and pdds_pd_term.
`default_nettype none

module pdds_ctrl #(
   parameter int COUNT_WIDTH    = 24,
   parameter int GAIN_FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire pdds_pkg::op_type              op,
   input  wire logic signed [COUNT_WIDTH-1:0] left_count,
   input  wire logic signed [COUNT_WIDTH-1:0] right_count,
   input  wire logic signed [COUNT_WIDTH-1:0] middle_count,
   input  wire logic [COUNT_WIDTH-1:0]        target,
   input  wire pdds_pkg::cfg_type             cfg,
   output pdds_pkg::rsp_type                  rsp
);
   import pdds_pkg::*;

   localparam int ERR_W = COUNT_WIDTH + 1;
   localparam int Q_W   = ERR_W + GAIN_W + 3;

   logic signed [ERR_W-1:0] pos_err_ff, pos_err_in;
   logic signed [ERR_W-1:0] prev_pos_ff, prev_pos_in;
   logic signed [ERR_W-1:0] head_err_ff, head_err_in;
   logic signed [ERR_W-1:0] prev_head_ff, prev_head_in;
   logic [SPEED_W-1:0]      floor_ff, floor_in;
   logic [CORR_W-1:0]       corr_ff, corr_in;
   logic                    finished_ff, finished_in;

   logic signed [Q_W-1:0]   q, hq;
   logic                    q_neg, hq_neg;
   logic [Q_W-1:0]          q_mag, hq_mag, q_int, hq_int;
   logic [Q_W-1:0]          max_lim, floor_lim;
   logic [SPEED_W-1:0]      drive_mag, head_mag;
   logic [CMD_W-1:0]        drive_trunc, head_cmd;
   logic signed [ERR_W-1:0] target_ext, sum_lr, avg_num, avg_half;
   logic signed [ERR_W-1:0] new_pos, new_head;

   pdds_pd_term #(.ERR_W(ERR_W), .Q_W(Q_W)) u_pos_term (
      .kp   (cfg.kp_gain),
      .kd   (cfg.kd_gain),
      .err  (pos_err_ff),
      .prev (prev_pos_ff),
      .q    (q)
   );

   pdds_pd_term #(.ERR_W(ERR_W), .Q_W(Q_W)) u_head_term (
      .kp   (cfg.heading_kp_gain),
      .kd   (cfg.heading_kd_gain),
      .err  (head_err_ff),
      .prev (prev_head_ff),
      .q    (hq)
   );

   // magnitudes and truncated integer parts
   assign q_neg     = q[Q_W-1];
   assign hq_neg    = hq[Q_W-1];
   assign q_mag     = q_neg  ? Q_W'(-q)  : Q_W'(q);
   assign hq_mag    = hq_neg ? Q_W'(-hq) : Q_W'(hq);
   assign q_int     = q_mag  >> GAIN_FRAC_BITS;
   assign hq_int    = hq_mag >> GAIN_FRAC_BITS;
   assign max_lim   = Q_W'(cfg.max_speed) << GAIN_FRAC_BITS;
   assign floor_lim = Q_W'(floor_ff) << GAIN_FRAC_BITS;

   // only reached when floor <= |q| <= max, so the integer part fits 7 bits
   assign drive_mag   = q_int[SPEED_W-1:0];
   assign drive_trunc = q_neg ? -CMD_W'(drive_mag) : CMD_W'(drive_mag);

   assign head_mag = (hq_int > Q_W'(HEAD_LIMIT)) ? HEAD_LIMIT : hq_int[SPEED_W-1:0];
   assign head_cmd = hq_neg ? -CMD_W'(head_mag) : CMD_W'(head_mag);

   // encoder average, truncated toward zero
   assign target_ext = $signed({target[COUNT_WIDTH-1], target});
   assign sum_lr     = $signed({left_count[COUNT_WIDTH-1], left_count})
                     + $signed({right_count[COUNT_WIDTH-1], right_count});
   assign avg_num    = sum_lr + $signed({{(ERR_W-1){1'b0}}, sum_lr[ERR_W-1]});
   assign avg_half   = avg_num >>> 1;
   assign new_pos    = target_ext - avg_half;
   assign new_head   = -$signed({middle_count[COUNT_WIDTH-1], middle_count});

   always_comb begin
      pos_err_in   = pos_err_ff;
      prev_pos_in  = prev_pos_ff;
      head_err_in  = head_err_ff;
      prev_head_in = prev_head_ff;
      floor_in     = floor_ff;
      corr_in      = corr_ff;
      finished_in  = finished_ff;
      rsp          = '0;

      if (op == OP_START) begin
         pos_err_in   = target_ext;
         prev_pos_in  = '0;
         head_err_in  = '0;
         prev_head_in = '0;
         floor_in     = cfg.min_speed;
         corr_in      = '0;
         finished_in  = 1'b0;
      end else if (finished_ff || (pos_err_ff == '0)) begin
         finished_in  = 1'b1;
         rsp.done_res = 1'b1;
      end else if ((q_mag < floor_lim) && !(q_mag > max_lim)
                   && !(corr_ff < cfg.max_corrections)) begin
         // correction limit reached: give up
         finished_in  = 1'b1;
         rsp.done_res = 1'b1;
         rsp.gave_up  = 1'b1;
      end else begin
         if (q_mag > max_lim) begin
            rsp.drive_cmd = q_neg ? -CMD_W'(cfg.max_speed) : CMD_W'(cfg.max_speed);
         end else if (q_mag < floor_lim) begin
            if (q_neg) begin
               floor_in      = LOW_FLOOR;
               corr_in       = corr_ff + 1'b1;
               rsp.drive_cmd = -CMD_W'(LOW_FLOOR);
            end else begin
               rsp.drive_cmd = CMD_W'(floor_ff);
            end
         end else begin
            rsp.drive_cmd = drive_trunc;
         end
         rsp.heading_cmd = head_cmd;
         prev_pos_in     = pos_err_ff;
         pos_err_in      = new_pos;
         prev_head_in    = head_err_ff;
         head_err_in     = new_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= 1'b1;
      end else if (fire) begin
         finished_ff <= finished_in;
      end
   end

   // payload state: defined by the start beat before it is used
   always_ff @(posedge clock) begin
      if (fire) begin
         pos_err_ff   <= pos_err_in;
         prev_pos_ff  <= prev_pos_in;
         head_err_ff  <= head_err_in;
         prev_head_ff <= prev_head_in;
         floor_ff     <= floor_in;
         corr_ff      <= corr_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pd_drive_straight_controller.sv
// Top level of the drive-straight PD controller: beat registers on both sides,
// configuration port and control core. Depends on pdds_pkg, pdds_csr, pdds_ctrl.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------------
//  req_     | in  | req_tvalid/req_tready | tuser op; tdata left, right, middle counts
//  rsp_     | out | rsp_tvalid/rsp_tready | tdata drive, heading, done, gave_up
//  csr_     | in  | csr_valid/csr_ready   | csr_addr register index, csr_data value
//
// One beat in per cycle while rsp_ is not stalled, one result beat out per beat.
// The path runs from the input register through one pass of both PD multiplies,
// the clamp and the error update into the output register. The move state feeds
// back within that single pass, so consecutive ticks follow each other with no gap.
// Synchronous reset leaves the move finished (ticks answer done) and loads the
// register defaults. A stalled rsp_ holds its beat; the input register still
// takes a new beat while it is empty. csr_ready is always high.
`default_nettype none

module pd_drive_straight_controller #(
   parameter int COUNT_WIDTH    = 24,
   parameter int GAIN_FRAC_BITS = 12,
   localparam int REQ_DATA_W    = ((3 * COUNT_WIDTH + 7) / 8) * 8,
   localparam int CSR_DATA_W    = (COUNT_WIDTH > pdds_pkg::GAIN_W) ? COUNT_WIDTH
                                                                   : pdds_pkg::GAIN_W
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request beats
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [REQ_DATA_W-1:0]           req_tdata,  // left_count, right_count,
                                                            // middle_count, zero pad
   input  wire logic                            req_tuser,  // op: 0 start, 1 tick
   // result beats
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [pdds_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // drive_cmd[7:0],
                                                            // heading_cmd[15:8],
                                                            // done_res[16], gave_up[17]
   // configuration writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pdds_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0]           csr_data
);
   import pdds_pkg::*;

   logic                          in_valid_ff, in_valid_in;
   op_type                        in_op_ff;
   logic signed [COUNT_WIDTH-1:0] in_left_ff, in_right_ff, in_middle_ff;
   logic                          out_valid_ff, out_valid_in;
   rsp_type                       out_rsp_ff;

   logic                          advance;
   logic                          fire;
   logic                          req_beat;
   logic [COUNT_WIDTH-1:0]        target;
   cfg_type                       cfg;
   rsp_type                       rsp;

   // output register moves when empty or drained; the input stage follows it
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_op_ff     <= op_type'(req_tuser);
         in_left_ff   <= req_tdata[COUNT_WIDTH-1:0];
         in_right_ff  <= req_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
         in_middle_ff <= req_tdata[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
      end
      if (fire) begin
         out_rsp_ff <= rsp;
      end
   end

   assign csr_ready = 1'b1;

   pdds_csr #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .CSR_DATA_W  (CSR_DATA_W)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid),
      .wr_addr (csr_addr),
      .wr_data (csr_data),
      .target  (target),
      .cfg     (cfg)
   );

   pdds_ctrl #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .op           (in_op_ff),
      .left_count   (in_left_ff),
      .right_count  (in_right_ff),
      .middle_count (in_middle_ff),
      .target       (target),
      .cfg          (cfg),
      .rsp          (rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_rsp_ff);

endmodule

`default_nettype wire
